// ===== hdl/lsp_pkg.sv =====
// Shared types and constants for the LED strip pixel store and encoder.
package lsp_pkg;

	// Field widths fixed by the interface
	localparam int CNT_W          = 7;
	localparam int PAT_W          = 8;
	localparam int IDX_IN_W       = 16;
	localparam int CHAN_W         = 8;
	localparam int COLOR_W        = 24;
	localparam int BITS_PER_PIXEL = 24;
	localparam int BIT_CNT_W      = 5;
	localparam int STEP_W         = $clog2(IDX_IN_W);

	// Defaults
	localparam int MAX_PIXELS_DEF   = 64;
	localparam int RESET_COUNT      = 64;
	localparam int RESET_ONE_PAT    = 248;
	localparam int RESET_ZERO_PAT   = 192;
	localparam int FIFO_DEPTH       = 2;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_FILL  = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_EMIT  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_PIXEL_COUNT = 2'd0,
		REG_ONE_PAT     = 2'd1,
		REG_ZERO_PAT    = 2'd2
	} reg_idx_t;

	// Command handed from the front to the back
	typedef struct packed {
		mode_t              mode;
		logic [CNT_W-1:0]   idx;
		logic [COLOR_W-1:0] colour;
	} cmd_t;

	// Live configuration seen by both halves
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [PAT_W-1:0] one_pat;
		logic [PAT_W-1:0] zero_pat;
	} cfg_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_FILL,
		B_EMIT
	} back_state_t;

endpackage

// ===== hdl/lsp_fifo.sv =====
// Small two-entry queue used between the halves and on the result side.
module lsp_fifo #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] wdata,
	output logic          full,
	input  logic          pop,
	output logic [DW-1:0] rdata,
	output logic          empty
);
	import lsp_pkg::*;

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int LVL_W = $clog2(FIFO_DEPTH + 1);

	logic [DW-1:0]    slot_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (level_q == LVL_W'(FIFO_DEPTH));
	assign empty   = (level_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	// Store the incoming beat
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !do_push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/lsp_front.sv =====
// Front half: accepts items and reduces the signed index modulo the pixel count.
module lsp_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lsp_pkg::cfg_t               cfg,
	input  logic                        clearing,
	input  logic                        push,
	output logic                        full,
	input  logic [1:0]                  mode,
	input  logic signed [15:0]          pixel_index,
	input  logic [7:0]                  red,
	input  logic [7:0]                  green,
	input  logic [7:0]                  blue,
	output logic                        cmd_push,
	output lsp_pkg::cmd_t               cmd,
	input  logic                        cmd_full
);
	import lsp_pkg::*;

	front_state_t          state_q;
	front_state_t          state_nxt;
	mode_t                 mode_q;
	logic                  neg_q;
	logic [IDX_IN_W-1:0]   mag_q;
	logic [CNT_W-1:0]      rem_q;
	logic [STEP_W-1:0]     step_q;
	logic [COLOR_W-1:0]    colour_q;
	logic [CNT_W:0]        trial;
	logic [CNT_W-1:0]      rem_nxt;
	logic                  accept;
	mode_t                 in_mode;

	assign in_mode = mode_t'(mode);
	assign accept  = push && !full;

	// One restoring-remainder step per cycle
	always_comb begin
		trial = {rem_q, mag_q[IDX_IN_W-1]};
		if (trial >= {1'b0, cfg.count}) begin
			rem_nxt = CNT_W'(trial - {1'b0, cfg.count});
		end else begin
			rem_nxt = trial[CNT_W-1:0];
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			F_IDLE: begin
				if (accept && cfg.count != '0) begin
					if (in_mode inside {MODE_FILL, MODE_CLEAR}) begin
						state_nxt = F_PUSH;
					end else begin
						state_nxt = F_DIV;
					end
				end
			end
			F_DIV: begin
				if (step_q == STEP_W'(IDX_IN_W - 1)) begin
					state_nxt = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!cmd_full) begin
					state_nxt = F_IDLE;
				end
			end
			default: state_nxt = F_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		full        = (state_q != F_IDLE) || clearing;
		cmd_push    = (state_q == F_PUSH);
		cmd.mode    = mode_q;
		cmd.colour  = colour_q;
		cmd.idx     = (neg_q && rem_q != '0) ? cfg.count - rem_q : rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Capture the item, then shift the magnitude through the divider
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && accept) begin
			mode_q   <= in_mode;
			neg_q    <= pixel_index[IDX_IN_W-1];
			mag_q    <= pixel_index[IDX_IN_W-1] ? IDX_IN_W'(-pixel_index)
			                                    : IDX_IN_W'(pixel_index);
			rem_q    <= '0;
			step_q   <= '0;
			colour_q <= {red, green, blue};
		end else if (state_q == F_DIV) begin
			mag_q  <= {mag_q[IDX_IN_W-2:0], 1'b0};
			rem_q  <= rem_nxt;
			step_q <= step_q + 1'b1;
		end
	end

endmodule

// ===== hdl/lsp_back.sv =====
// Back half: owns the pixel memory, runs write, fill, clear and emit commands.
module lsp_back #(
	parameter int MAX_PIXELS = lsp_pkg::MAX_PIXELS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  lsp_pkg::cfg_t cfg,
	output logic          clearing,
	input  lsp_pkg::cmd_t cmd,
	input  logic          cmd_empty,
	output logic          cmd_pop,
	output logic          out_push,
	output logic [7:0]    out_byte,
	output logic          out_last,
	input  logic          out_full
);
	import lsp_pkg::*;

	localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

	logic [COLOR_W-1:0]   mem [MAX_PIXELS];
	logic [COLOR_W-1:0]   rd_q;
	back_state_t          state_q;
	back_state_t          state_nxt;
	logic [ADDR_W-1:0]    clr_ptr_q;
	logic [CNT_W-1:0]     fill_ptr_q;
	logic [COLOR_W-1:0]   fill_colour_q;
	logic [BIT_CNT_W-1:0] bit_cnt_q;
	logic                 we;
	logic [ADDR_W-1:0]    waddr;
	logic [COLOR_W-1:0]   wdata;
	logic                 re;
	logic                 cur_bit;
	logic                 clr_done;
	logic                 fill_done;
	logic                 emit_done;

	assign clr_done  = (clr_ptr_q == ADDR_W'(MAX_PIXELS - 1));
	assign fill_done = (fill_ptr_q == cfg.count - 1'b1);
	assign emit_done = (bit_cnt_q == BIT_CNT_W'(BITS_PER_PIXEL - 1));
	assign cur_bit   = rd_q[BIT_CNT_W'(BITS_PER_PIXEL - 1) - bit_cnt_q];

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			B_CLEAR: begin
				if (clr_done) begin
					state_nxt = B_IDLE;
				end
			end
			B_IDLE: begin
				if (!cmd_empty) begin
					case (cmd.mode)
						MODE_FILL, MODE_CLEAR: state_nxt = B_FILL;
						MODE_EMIT:             state_nxt = B_EMIT;
						default:               state_nxt = B_IDLE;
					endcase
				end
			end
			B_FILL: begin
				if (fill_done) begin
					state_nxt = B_IDLE;
				end
			end
			B_EMIT: begin
				if (!out_full && emit_done) begin
					state_nxt = B_IDLE;
				end
			end
			default: state_nxt = B_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		clearing = (state_q == B_CLEAR);
		cmd_pop  = (state_q == B_IDLE) && !cmd_empty;
		we       = 1'b0;
		waddr    = ADDR_W'(cmd.idx);
		wdata    = cmd.colour;
		re       = 1'b0;
		out_push = (state_q == B_EMIT) && !out_full;
		out_byte = cur_bit ? cfg.one_pat : cfg.zero_pat;
		out_last = emit_done;
		case (state_q)
			B_CLEAR: begin
				we    = 1'b1;
				waddr = clr_ptr_q;
				wdata = '0;
			end
			B_IDLE: begin
				we = !cmd_empty && (cmd.mode == MODE_WRITE);
				re = !cmd_empty && (cmd.mode == MODE_EMIT);
			end
			B_FILL: begin
				we    = 1'b1;
				waddr = ADDR_W'(fill_ptr_q);
				wdata = fill_colour_q;
			end
			default: ;
		endcase
	end

	// Pixel memory with registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[ADDR_W'(cmd.idx)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_CLEAR;
			clr_ptr_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == B_CLEAR) begin
				clr_ptr_q <= clr_ptr_q + 1'b1;
			end
		end
	end

	// Walk counters for fill and emit
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && !cmd_empty) begin
			fill_ptr_q    <= '0;
			fill_colour_q <= (cmd.mode == MODE_FILL) ? cmd.colour : '0;
			bit_cnt_q     <= '0;
		end else if (state_q == B_FILL) begin
			fill_ptr_q <= fill_ptr_q + 1'b1;
		end else if (out_push) begin
			bit_cnt_q <= bit_cnt_q + 1'b1;
		end
	end

endmodule

// ===== hdl/led_strip_pixel_store_encoder_core.sv =====
// Top level of the LED strip pixel store and serial bit encoder.
//
//   channel   direction  handshake                beat contents
//   input     in         push / full              mode, pixel_index, red, green, blue
//   result    out        empty / pop              code_byte, pixel_last
//   config    in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Write and emit pass through the 16-step index remainder unit in the front;
// fill and clear skip it. The back writes one pixel per cycle for fill and clear,
// and emit does one memory read, then sends one code byte per cycle while the
// result queue is not full. After reset the back sweeps MAX_PIXELS entries to
// zero, holding full high during the sweep. A stalled result side holds the
// back in emit; the two-entry command queue lets the front keep working.
module led_strip_pixel_store_encoder_core #(
	parameter int MAX_PIXELS = lsp_pkg::MAX_PIXELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         mode,
	input  logic signed [15:0] pixel_index,
	input  logic [7:0]         red,
	input  logic [7:0]         green,
	input  logic [7:0]         blue,
	output logic               empty,
	input  logic               pop,
	output logic [7:0]         code_byte,
	output logic               pixel_last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);
	import lsp_pkg::*;

	localparam int CMD_W = $bits(cmd_t);
	localparam int OUT_W = PAT_W + 1;

	logic [CNT_W-1:0] count_q;
	logic [PAT_W-1:0] one_pat_q;
	logic [PAT_W-1:0] zero_pat_q;
	cfg_t             cfg;
	logic             clearing;
	logic             cmd_push;
	logic             cmd_full;
	logic             cmd_pop;
	logic             cmd_empty;
	cmd_t             cmd_in;
	logic [CMD_W-1:0] cmd_out_bits;
	cmd_t             cmd_out;
	logic             out_push;
	logic             out_full;
	logic [PAT_W-1:0] out_byte;
	logic             out_last;
	logic [OUT_W-1:0] out_bits;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= CNT_W'(RESET_COUNT);
			one_pat_q  <= PAT_W'(RESET_ONE_PAT);
			zero_pat_q <= PAT_W'(RESET_ZERO_PAT);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PIXEL_COUNT: count_q    <= cfg_data[CNT_W-1:0];
				REG_ONE_PAT:     one_pat_q  <= cfg_data;
				REG_ZERO_PAT:    zero_pat_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Saturate the active count to the store size
	always_comb begin
		cfg.count    = (32'(count_q) > MAX_PIXELS) ? CNT_W'(MAX_PIXELS) : count_q;
		cfg.one_pat  = one_pat_q;
		cfg.zero_pat = zero_pat_q;
	end

	lsp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.clearing    (clearing),
		.push        (push),
		.full        (full),
		.mode        (mode),
		.pixel_index (pixel_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.cmd_push    (cmd_push),
		.cmd         (cmd_in),
		.cmd_full    (cmd_full)
	);

	lsp_fifo #(
		.DW (CMD_W)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_out_bits),
		.empty  (cmd_empty)
	);

	assign cmd_out = cmd_t'(cmd_out_bits);

	lsp_back #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.clearing  (clearing),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.out_push  (out_push),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.out_full  (out_full)
	);

	lsp_fifo #(
		.DW (OUT_W)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  ({out_byte, out_last}),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_bits),
		.empty  (empty)
	);

	assign code_byte  = out_bits[OUT_W-1:1];
	assign pixel_last = out_bits[0];

	// Mapped index of a write or emit lands inside the active range
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_push && (cmd_in.mode == MODE_WRITE || cmd_in.mode == MODE_EMIT))
		|-> (cmd_in.idx < cfg.count))
		else $error("mapped pixel index outside active range");

	// No item is taken while the store is being swept after reset
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> full)
		else $error("input accepted during reset sweep");

	// The back never offers a code byte to a full result queue
	a_no_out_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result queue overflow");

	// After the last byte of a pixel the back stops emitting
	a_last_ends_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(out_push && out_last) |=> !out_push)
		else $error("emit continued past last byte");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the LED strip pixel store and serial bit encoder.
`timescale 1ns / 100ps

module testbench;
	import lsp_pkg::*;

	localparam int MAX_PIX         = 64;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 55;
	localparam int QUIET_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int MAX_REPORTS     = 10;

	// One command beat; fixed marks a row whose emitted code bytes are all fixed_code
	typedef struct {
		mode_t              mode;
		logic signed [15:0] idx;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		bit                 fixed;
		logic [7:0]         fixed_code;
	} pix_cmd_t;

	typedef struct {
		logic [7:0] code;
		logic       last;
	} code_beat_t;

	typedef struct {
		int count;
		int one_pat;
		int zero_pat;
		int gap_pct;
		int stall_pct;
	} phase_cfg_t;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [1:0]         mode;
	logic signed [15:0] pixel_index;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;
	logic               empty;
	logic               pop;
	logic [7:0]         code_byte;
	logic               pixel_last;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [7:0]         cfg_data;

	// Shadow copy of the pixel store and the live registers
	logic [23:0]  pixel_mem [MAX_PIX];
	logic [6:0]   live_count;
	logic [7:0]   live_one_pat;
	logic [7:0]   live_zero_pat;
	code_beat_t   code_beats_q [$];

	int unsigned gap_pct        = 0;
	int unsigned stall_pct      = 0;
	int          mismatch_count = 0;

	// Directed rows, run at the reset register values
	pix_cmd_t dir_tab [18] = '{
		'{MODE_EMIT,   16'sd0,     8'h00, 8'h00, 8'h00, 1'b1, 8'd192},
		'{MODE_EMIT,   -16'sd1,    8'hff, 8'hff, 8'hff, 1'b1, 8'd192},
		'{MODE_WRITE,  16'sd0,     8'hff, 8'hff, 8'hff, 1'b0, 8'd0},
		'{MODE_EMIT,   16'sd0,     8'h00, 8'h00, 8'h00, 1'b1, 8'd248},
		'{MODE_EMIT,   16'sd64,    8'h5a, 8'h5a, 8'h5a, 1'b1, 8'd248},
		'{MODE_EMIT,   -16'sd64,   8'ha5, 8'ha5, 8'ha5, 1'b1, 8'd248},
		'{MODE_WRITE,  -16'sd1,    8'ha5, 8'h3c, 8'h0f, 1'b0, 8'd0},
		'{MODE_EMIT,   16'sd63,    8'h00, 8'h00, 8'h00, 1'b0, 8'd0},
		'{MODE_EMIT,   16'sh7fff,  8'h00, 8'h00, 8'h00, 1'b0, 8'd0},
		'{MODE_WRITE,  16'sh8000,  8'h80, 8'h01, 8'h7e, 1'b0, 8'd0},
		'{MODE_EMIT,   16'sd0,     8'h00, 8'h00, 8'h00, 1'b0, 8'd0},
		'{MODE_FILL,   16'sd7,     8'h12, 8'h34, 8'h56, 1'b0, 8'd0},
		'{MODE_EMIT,   16'sd17,    8'h00, 8'h00, 8'h00, 1'b0, 8'd0},
		'{MODE_EMIT,   16'sh8000,  8'h00, 8'h00, 8'h00, 1'b0, 8'd0},
		'{MODE_CLEAR,  16'sd3,     8'hff, 8'hff, 8'hff, 1'b0, 8'd0},
		'{MODE_EMIT,   16'sd5,     8'h00, 8'h00, 8'h00, 1'b1, 8'd192},
		'{MODE_WRITE,  16'sd1,     8'hff, 8'h00, 8'hff, 1'b0, 8'd0},
		'{MODE_EMIT,   -16'sd63,   8'h00, 8'h00, 8'h00, 1'b0, 8'd0}
	};

	// Register settings and idling per phase: zero count, saturated count, pattern extremes
	phase_cfg_t phase_tab [PHASES] = '{
		'{64,  248, 192, 0,  0},
		'{1,   255, 0,   82, 0},
		'{0,   170, 85,  0,  82},
		'{127, 0,   255, 29, 29},
		'{37,  15,  240, 0,  0},
		'{64,  248, 192, 82, 0},
		'{100, 1,   128, 0,  82},
		'{5,   254, 127, 29, 29}
	};

	led_strip_pixel_store_encoder_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.mode        (mode),
		.pixel_index (pixel_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.empty       (empty),
		.pop         (pop),
		.code_byte   (code_byte),
		.pixel_last  (pixel_last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Count above the store size saturates
	function automatic int unsigned active_pixels();
		return (live_count > 7'(MAX_PIX)) ? MAX_PIX : live_count;
	endfunction

	// Truncating remainder, negative remainders wrap from the end
	function automatic int unsigned wrap_index(logic signed [15:0] raw, int unsigned n);
		int r;
		r = int'(raw) % int'(n);
		if (r < 0) r += int'(n);
		return r;
	endfunction

	// Update the shadow store and queue the code beats one command causes
	function automatic void predict_code_beats(pix_cmd_t c);
		int unsigned n;
		logic [23:0] px;
		code_beat_t  b;
		n = active_pixels();
		if (n == 0) return;
		case (c.mode)
			MODE_WRITE: begin
				pixel_mem[wrap_index(c.idx, n)] = {c.red, c.green, c.blue};
			end
			MODE_FILL, MODE_CLEAR: begin
				px = (c.mode == MODE_FILL) ? {c.red, c.green, c.blue} : 24'h0;
				for (int i = 0; i < n; i++) pixel_mem[i] = px;
			end
			default: begin
				px = pixel_mem[wrap_index(c.idx, n)];
				for (int i = 0; i < 24; i++) begin
					if (c.fixed) b.code = c.fixed_code;
					else b.code = px[23 - i] ? live_one_pat : live_zero_pat;
					b.last = (i == 23);
					code_beats_q.push_back(b);
				end
			end
		endcase
	endfunction

	function automatic logic [7:0] rand_channel();
		int unsigned sel;
		sel = $urandom_range(7);
		if (sel == 0) return 8'h00;
		if (sel == 1) return 8'hff;
		return 8'($urandom());
	endfunction

	// Random command: indexes from -n to n-1 half the time, some extremes and raw 16-bit values
	function automatic pix_cmd_t rand_cmd();
		pix_cmd_t    c;
		int unsigned n;
		int unsigned m;
		int unsigned sel;
		n   = active_pixels();
		m   = $urandom_range(99);
		sel = $urandom_range(9);
		c.mode = (m < 35) ? MODE_WRITE : (m < 47) ? MODE_FILL : (m < 60) ? MODE_CLEAR : MODE_EMIT;
		if (sel < 5 && n != 0)
			c.idx = 16'(int'($urandom_range(2 * n - 1)) - int'(n));
		else if (sel == 5)
			c.idx = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
		else
			c.idx = 16'($urandom());
		c.red        = rand_channel();
		c.green      = rand_channel();
		c.blue       = rand_channel();
		c.fixed      = 1'b0;
		c.fixed_code = 8'h00;
		return c;
	endfunction

	// Hold one register beat until ready, then track the new value
	task automatic write_reg(reg_idx_t r, logic [7:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		case (r)
			REG_PIXEL_COUNT: live_count    = v[6:0];
			REG_ONE_PAT:     live_one_pat  = v;
			REG_ZERO_PAT:    live_zero_pat = v;
			default: ;
		endcase
	endtask

	// Idle at random, then hold the command until full drops
	task automatic send_cmd(pix_cmd_t c);
		while ($urandom_range(99) < gap_pct) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push        <= 1'b1;
		mode        <= c.mode;
		pixel_index <= c.idx;
		red         <= c.red;
		green       <= c.green;
		blue        <= c.blue;
		do @(posedge clk); while (full);
		predict_code_beats(c);
	endtask

	// Drop push, wait for every expected beat, then let trailing work finish
	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (code_beats_q.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// Main sequence
	initial begin
		arst_n      = 1'b0;
		push        = 1'b0;
		mode        = MODE_WRITE;
		pixel_index = '0;
		red         = '0;
		green       = '0;
		blue        = '0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_PIXEL_COUNT;
		cfg_data    = '0;
		foreach (pixel_mem[i]) pixel_mem[i] = 24'h0;
		live_count    = 7'(RESET_COUNT);
		live_one_pat  = 8'(RESET_ONE_PAT);
		live_zero_pat = 8'(RESET_ZERO_PAT);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[k]) send_cmd(dir_tab[k]);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			write_reg(REG_PIXEL_COUNT, 8'(phase_tab[p].count));
			write_reg(REG_ONE_PAT, 8'(phase_tab[p].one_pat));
			write_reg(REG_ZERO_PAT, 8'(phase_tab[p].zero_pat));
			@(negedge clk);
			cfg_valid <= 1'b0;
			gap_pct   = phase_tab[p].gap_pct;
			stall_pct = phase_tab[p].stall_pct;
			repeat (ITEMS_PER_PHASE) send_cmd(rand_cmd());
		end
		settle();

		if (mismatch_count == 0 && code_beats_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Result side: stall at random, per phase
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			pop <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Check each popped beat against the oldest expectation
	always @(posedge clk) begin
		code_beat_t want;
		if (arst_n && pop && !empty) begin
			if (code_beats_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected beat: code_byte %h pixel_last %b", code_byte, pixel_last);
			end else begin
				want = code_beats_q.pop_front();
				if (code_byte !== want.code || pixel_last !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("beat mismatch: code_byte exp %h got %h, pixel_last exp %b got %b",
							want.code, code_byte, want.last, pixel_last);
				end
			end
		end
	end

	// Abort when no beat moves on any channel for too long
	initial begin
		int stalled;
		stalled = 0;
		while (stalled < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) stalled = 0;
			else stalled++;
		end
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/lsp_pkg.sv
hdl/lsp_fifo.sv
hdl/lsp_front.sv
hdl/lsp_back.sv
hdl/led_strip_pixel_store_encoder_core.sv
tb/testbench.sv
